FILE: src/sme_pkg.sv
package sme_pkg;

    // Request kinds.
    localparam logic [1:0] KIND_PATTERN = 2'd0;
    localparam logic [1:0] KIND_SUBJECT = 2'd1;
    localparam logic [1:0] KIND_RUN     = 2'd2;
    localparam logic [1:0] KIND_UNUSED  = 2'd3;

    // Match modes.
    localparam logic [2:0] MODE_CONTAINS = 3'd0;
    localparam logic [2:0] MODE_BEGINS   = 3'd1;
    localparam logic [2:0] MODE_EQUAL    = 3'd2;
    localparam logic [2:0] MODE_COMPARE  = 3'd3;
    localparam logic [2:0] MODE_KW_PREF  = 3'd4;
    localparam logic [2:0] MODE_KW_EXACT = 3'd5;
    localparam logic [2:0] MODE_PATTERN  = 3'd6;
    localparam logic [2:0] MODE_UNUSED   = 3'd7;

    // Error codes.
    localparam logic [1:0] ERR_OK       = 2'd0;
    localparam logic [1:0] ERR_PATTERN  = 2'd1;
    localparam logic [1:0] ERR_OVERFLOW = 2'd2;
    localparam logic [1:0] ERR_REDIRECT = 2'd3;

    // Characters.
    localparam logic [7:0] CH_COMMA  = 8'h2C;
    localparam logic [7:0] CH_EQUALS = 8'h3D;
    localparam logic [7:0] CH_DASH   = 8'h2D;
    localparam logic [7:0] CH_UNDER  = 8'h5F;
    localparam logic [7:0] CH_LOW_A  = 8'h61;
    localparam logic [7:0] CH_LOW_Z  = 8'h7A;
    localparam logic [7:0] CASE_GAP  = 8'd32;

    typedef logic signed [13:0] t_mval;

    localparam t_mval MV_ZERO    = 14'sd0;
    localparam t_mval MV_ONE     = 14'sd1;
    localparam t_mval MV_NEG_ONE = -14'sd1;

    typedef struct packed {
        logic [1:0] kind;
        logic [7:0] char_byte;
        logic [2:0] match_mode;
        logic       fold_case;
        logic       equals_is_plain;
    } t_req;

    typedef struct packed {
        t_mval      match_value;
        logic [1:0] error_code;
    } t_res;

    typedef enum logic [4:0] {
        S_IDLE,
        S_SAME_A,
        S_SAME_B,
        S_SAME_C,
        S_SPAN_A,
        S_SPAN_B,
        S_CONT_CK,
        S_BOOL_CK,
        S_CMP_RD,
        S_CMP_CK,
        S_KW_TOP,
        S_KW_J,
        S_KW_S1,
        S_KW_K,
        S_KW_S2,
        S_KW_HIT,
        S_KW_MISS,
        S_KW_XL
    } t_state;

    // When en is set, upper-case letters and turn a dash into an underscore.
    function automatic logic [7:0] fold_byte(input logic [7:0] c, input logic en);
        logic [7:0] r;
        r = c;
        if (en) begin
            if (c >= CH_LOW_A && c <= CH_LOW_Z) begin
                r = c - CASE_GAP;
            end else if (c == CH_DASH) begin
                r = CH_UNDER;
            end
        end
        return r;
    endfunction

endpackage

FILE: src/sme_ram.sv
module sme_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

FILE: src/string_match_engine.sv
// Channel   | Handshake             | Payload             | Direction
// ----------+-----------------------+---------------------+----------
// request   | i_start, o_busy       | i_req (t_req)       | in
// result    | o_done (strobe)       | o_res (t_res)       | out
//
// A load request (search or subject byte) is taken while the block is idle;
// loads may follow back to back. A run request holds o_busy high while a
// sequencer walks the two byte memories through one registered read port
// each, comparing byte pairs, scanning bytes for a keyword boundary, or
// comparing the two strings byte by byte in compare mode.
// The result appears on o_res for exactly one cycle with o_done high, and
// the block is idle again in that same cycle; the receiver cannot stall it.
// Reset is synchronous and active low; it empties both strings.
module string_match_engine #(
    parameter int SUBJECT_DEPTH = 4096,
    parameter int PATTERN_DEPTH = 256,
    parameter int MAX_REDIRECTS = 16
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_start,
    input  sme_pkg::t_req i_req,
    output logic          o_busy,
    output logic          o_done,
    output sme_pkg::t_res o_res
);

    // Subject and pattern lengths, memory addresses, and a common width
    // for positions that can run one past the end of the subject.
    localparam int SW  = $clog2(SUBJECT_DEPTH + 1);
    localparam int PLW = $clog2(PATTERN_DEPTH + 1);
    localparam int SA  = $clog2(SUBJECT_DEPTH);
    localparam int PA  = $clog2(PATTERN_DEPTH);
    localparam int LW  = ((SW > PLW) ? SW : PLW) + 1;
    localparam int RW  = $clog2(MAX_REDIRECTS + 2);

    sme_pkg::t_state r_state, n_state, r_ret, n_ret;

    logic [PLW-1:0] r_pl, n_pl;
    logic [SW-1:0]  r_dl, n_dl;
    logic           r_ovf, n_ovf;
    logic [2:0]     r_mode, n_mode;
    logic           r_fold, n_fold;
    logic           r_plain, n_plain;

    // Byte-compare unit: compares r_cn bytes from r_ca (pattern or subject)
    // with subject bytes from r_cb.
    logic [LW-1:0]  r_ca, n_ca, r_cb, n_cb, r_cn, n_cn, r_ct, n_ct;
    logic           r_csrc, n_csrc;
    logic           r_same, n_same;
    logic [7:0]     r_abyte, n_abyte;

    // Span unit: length of a subject run up to a separator or the end.
    logic [LW-1:0]  r_spp, n_spp, r_spt, n_spt, r_splen, n_splen;
    logic           r_speq, n_speq;
    logic           r_spend, n_spend;
    logic [7:0]     r_spch, n_spch;

    // Search state.
    logic [LW-1:0]  r_p, n_p;
    logic           r_ssrc, n_ssrc;
    logic [LW-1:0]  r_sp, n_sp, r_sl, n_sl;
    logic [RW-1:0]  r_red, n_red;
    logic [LW-1:0]  r_pos, n_pos, r_idx, n_idx, r_j, n_j;
    logic           r_prevend, n_prevend;
    logic           r_dend, n_dend;
    logic [7:0]     r_dch, n_dch;

    logic           r_done, n_done;
    sme_pkg::t_res  r_res, n_res;

    logic           accept;
    logic           pat_we, sub_we;
    logic [PA-1:0]  pat_raddr;
    logic [SA-1:0]  sub_raddr;
    logic [7:0]     pat_q, sub_q;
    logic [LW-1:0]  addr_a, addr_b, addr_sp;
    logic [LW-1:0]  pl_ext, dl_ext, next_pos;

    assign accept   = i_start && !o_busy;
    assign pat_we   = accept && i_req.kind == sme_pkg::KIND_PATTERN
                      && r_pl < PLW'(PATTERN_DEPTH);
    assign sub_we   = accept && i_req.kind == sme_pkg::KIND_SUBJECT
                      && r_dl < SW'(SUBJECT_DEPTH);
    assign addr_a   = r_ca + r_ct;
    assign addr_b   = r_cb + r_ct;
    assign addr_sp  = r_spp + r_spt;
    assign pl_ext   = LW'(r_pl);
    assign dl_ext   = LW'(r_dl);
    assign next_pos = r_pos + r_j + LW'(1);

    sme_ram #(.WIDTH(8), .DEPTH(PATTERN_DEPTH)) u_pat_ram (
        .i_clk   (i_clk),
        .i_we    (pat_we),
        .i_waddr (r_pl[PA-1:0]),
        .i_wdata (i_req.char_byte),
        .i_raddr (pat_raddr),
        .o_rdata (pat_q)
    );

    sme_ram #(.WIDTH(8), .DEPTH(SUBJECT_DEPTH)) u_sub_ram (
        .i_clk   (i_clk),
        .i_we    (sub_we),
        .i_waddr (r_dl[SA-1:0]),
        .i_wdata (i_req.char_byte),
        .i_raddr (sub_raddr),
        .o_rdata (sub_q)
    );

    // Next state and datapath.
    always_comb begin
        logic          fin;
        sme_pkg::t_res fres;
        logic          ae, be;

        n_state = r_state;   n_ret = r_ret;
        n_pl = r_pl;         n_dl = r_dl;         n_ovf = r_ovf;
        n_mode = r_mode;     n_fold = r_fold;     n_plain = r_plain;
        n_ca = r_ca;         n_cb = r_cb;         n_cn = r_cn;   n_ct = r_ct;
        n_csrc = r_csrc;     n_same = r_same;     n_abyte = r_abyte;
        n_spp = r_spp;       n_spt = r_spt;       n_splen = r_splen;
        n_speq = r_speq;     n_spend = r_spend;   n_spch = r_spch;
        n_p = r_p;           n_ssrc = r_ssrc;     n_sp = r_sp;   n_sl = r_sl;
        n_red = r_red;       n_pos = r_pos;       n_idx = r_idx; n_j = r_j;
        n_prevend = r_prevend;
        n_dend = r_dend;     n_dch = r_dch;
        n_done = 1'b0;       n_res = r_res;
        fin = 1'b0;
        fres.match_value = sme_pkg::MV_ZERO;
        fres.error_code = sme_pkg::ERR_OK;
        ae = 1'b0;
        be = 1'b0;

        unique case (r_state)
            sme_pkg::S_IDLE: begin
                if (accept) begin
                    unique case (i_req.kind)
                        sme_pkg::KIND_PATTERN: begin
                            if (pat_we) begin
                                n_pl = r_pl + PLW'(1);
                            end else begin
                                n_ovf = 1'b1;
                            end
                        end
                        sme_pkg::KIND_SUBJECT: begin
                            if (sub_we) begin
                                n_dl = r_dl + SW'(1);
                            end else begin
                                n_ovf = 1'b1;
                            end
                        end
                        sme_pkg::KIND_RUN: begin
                            n_mode  = i_req.match_mode;
                            n_fold  = i_req.fold_case;
                            n_plain = i_req.equals_is_plain;
                            n_ct    = '0;
                            n_ca    = '0;
                            n_cb    = '0;
                            n_cn    = pl_ext;
                            n_csrc  = 1'b0;
                            if (i_req.match_mode >= sme_pkg::MODE_PATTERN) begin
                                fin = 1'b1;
                                fres.error_code = sme_pkg::ERR_PATTERN;
                            end else if (r_ovf) begin
                                fin = 1'b1;
                                fres.error_code = sme_pkg::ERR_OVERFLOW;
                            end else begin
                                case (i_req.match_mode) inside
                                    sme_pkg::MODE_CONTAINS: begin
                                        if (r_pl == '0 || dl_ext < pl_ext) begin
                                            fin = 1'b1;
                                        end else begin
                                            n_p = '0;
                                            n_ret = sme_pkg::S_CONT_CK;
                                            n_state = sme_pkg::S_SAME_A;
                                        end
                                    end
                                    sme_pkg::MODE_BEGINS: begin
                                        if (r_pl == '0 || dl_ext < pl_ext) begin
                                            fin = 1'b1;
                                        end else begin
                                            n_ret = sme_pkg::S_BOOL_CK;
                                            n_state = sme_pkg::S_SAME_A;
                                        end
                                    end
                                    sme_pkg::MODE_EQUAL: begin
                                        if (dl_ext != pl_ext) begin
                                            fin = 1'b1;
                                        end else begin
                                            n_ret = sme_pkg::S_BOOL_CK;
                                            n_state = sme_pkg::S_SAME_A;
                                        end
                                    end
                                    sme_pkg::MODE_COMPARE: begin
                                        n_state = sme_pkg::S_CMP_RD;
                                    end
                                    sme_pkg::MODE_KW_PREF, sme_pkg::MODE_KW_EXACT: begin
                                        n_ssrc = 1'b0;
                                        n_sp = '0;
                                        n_sl = pl_ext;
                                        n_red = '0;
                                        n_pos = '0;
                                        n_idx = LW'(1);
                                        n_prevend = 1'b0;
                                        n_state = sme_pkg::S_KW_TOP;
                                    end
                                    default: begin
                                        fin = 1'b1;
                                    end
                                endcase
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end

            sme_pkg::S_SAME_A: begin
                if (r_ct == r_cn) begin
                    n_same = 1'b1;
                    n_state = r_ret;
                end else begin
                    n_state = sme_pkg::S_SAME_B;
                end
            end
            sme_pkg::S_SAME_B: begin
                n_abyte = r_csrc ? sub_q : pat_q;
                n_state = sme_pkg::S_SAME_C;
            end
            sme_pkg::S_SAME_C: begin
                if (sme_pkg::fold_byte(r_abyte, r_fold) != sme_pkg::fold_byte(sub_q, r_fold))
                begin
                    n_same = 1'b0;
                    n_state = r_ret;
                end else begin
                    n_ct = r_ct + LW'(1);
                    n_state = sme_pkg::S_SAME_A;
                end
            end

            sme_pkg::S_SPAN_A: begin
                if (addr_sp >= dl_ext) begin
                    n_splen = r_spt;
                    n_spend = 1'b1;
                    n_state = r_ret;
                end else begin
                    n_state = sme_pkg::S_SPAN_B;
                end
            end
            sme_pkg::S_SPAN_B: begin
                if (sub_q == sme_pkg::CH_COMMA || (r_speq && sub_q == sme_pkg::CH_EQUALS)) begin
                    n_splen = r_spt;
                    n_spend = 1'b0;
                    n_spch = sub_q;
                    n_state = r_ret;
                end else begin
                    n_spt = r_spt + LW'(1);
                    n_state = sme_pkg::S_SPAN_A;
                end
            end

            sme_pkg::S_CONT_CK: begin
                if (r_same) begin
                    fin = 1'b1;
                    fres.match_value = sme_pkg::t_mval'(r_p + LW'(1));
                end else if (r_p == dl_ext - pl_ext) begin
                    fin = 1'b1;
                end else begin
                    n_p = r_p + LW'(1);
                    n_cb = r_p + LW'(1);
                    n_ct = '0;
                    n_state = sme_pkg::S_SAME_A;
                end
            end
            sme_pkg::S_BOOL_CK: begin
                fin = 1'b1;
                fres.match_value = r_same ? sme_pkg::MV_ONE : sme_pkg::MV_ZERO;
            end

            sme_pkg::S_CMP_RD: begin
                n_state = sme_pkg::S_CMP_CK;
            end
            sme_pkg::S_CMP_CK: begin
                ae = r_ct >= pl_ext;
                be = r_ct >= dl_ext;
                if (ae && be) begin
                    fin = 1'b1;
                end else if (ae || (!be && pat_q < sub_q)) begin
                    fin = 1'b1;
                    fres.match_value = sme_pkg::MV_NEG_ONE;
                end else if (be || pat_q > sub_q) begin
                    fin = 1'b1;
                    fres.match_value = sme_pkg::MV_ONE;
                end else begin
                    n_ct = r_ct + LW'(1);
                    n_state = sme_pkg::S_CMP_RD;
                end
            end

            sme_pkg::S_KW_TOP: begin
                if (r_idx > LW'(1) && r_prevend) begin
                    fin = 1'b1;
                end else begin
                    n_spp = r_pos;
                    n_spt = '0;
                    n_speq = !r_plain;
                    n_ret = sme_pkg::S_KW_J;
                    n_state = sme_pkg::S_SPAN_A;
                end
            end
            sme_pkg::S_KW_J: begin
                n_j = r_splen;
                n_dend = r_spend;
                n_dch = r_spch;
                if (r_splen == '0) begin
                    fin = 1'b1;
                end else if (r_splen >= r_sl) begin
                    n_ca = r_sp;
                    n_cb = r_pos;
                    n_cn = r_sl;
                    n_ct = '0;
                    n_csrc = r_ssrc;
                    n_ret = sme_pkg::S_KW_S1;
                    n_state = sme_pkg::S_SAME_A;
                end else begin
                    n_state = sme_pkg::S_KW_MISS;
                end
            end
            sme_pkg::S_KW_S1: begin
                if (!r_same) begin
                    n_state = sme_pkg::S_KW_MISS;
                end else if (r_j == r_sl || (r_mode == sme_pkg::MODE_KW_PREF && r_dend)) begin
                    n_state = sme_pkg::S_KW_HIT;
                end else if (r_mode == sme_pkg::MODE_KW_EXACT) begin
                    n_state = sme_pkg::S_KW_MISS;
                end else begin
                    n_spp = next_pos;
                    n_spt = '0;
                    n_speq = 1'b1;
                    n_ret = sme_pkg::S_KW_K;
                    n_state = sme_pkg::S_SPAN_A;
                end
            end
            sme_pkg::S_KW_K: begin
                if (r_splen == '0 || r_sl > r_splen) begin
                    n_state = sme_pkg::S_KW_HIT;
                end else begin
                    n_ca = r_sp;
                    n_cb = next_pos;
                    n_cn = r_sl;
                    n_ct = '0;
                    n_csrc = r_ssrc;
                    n_ret = sme_pkg::S_KW_S2;
                    n_state = sme_pkg::S_SAME_A;
                end
            end
            sme_pkg::S_KW_S2: begin
                if (!r_same) begin
                    n_state = sme_pkg::S_KW_HIT;
                end else begin
                    fin = 1'b1;
                    fres.match_value = -sme_pkg::t_mval'(r_idx);
                end
            end
            sme_pkg::S_KW_HIT: begin
                if (r_dend || r_dch != sme_pkg::CH_EQUALS) begin
                    fin = 1'b1;
                    fres.match_value = sme_pkg::t_mval'(r_idx);
                end else if (r_red >= RW'(MAX_REDIRECTS)) begin
                    fin = 1'b1;
                    fres.error_code = sme_pkg::ERR_REDIRECT;
                end else begin
                    n_red = r_red + RW'(1);
                    n_spp = next_pos;
                    n_spt = '0;
                    n_speq = 1'b0;
                    n_ret = sme_pkg::S_KW_XL;
                    n_state = sme_pkg::S_SPAN_A;
                end
            end
            sme_pkg::S_KW_MISS: begin
                n_prevend = r_dend;
                n_pos = next_pos;
                n_idx = r_idx + LW'(1);
                n_state = sme_pkg::S_KW_TOP;
            end
            sme_pkg::S_KW_XL: begin
                n_ssrc = 1'b1;
                n_sp = next_pos;
                n_sl = r_splen;
                n_pos = '0;
                n_idx = LW'(1);
                n_prevend = 1'b0;
                n_state = sme_pkg::S_KW_TOP;
            end
            default: begin
                n_state = sme_pkg::S_IDLE;
            end
        endcase

        if (fin) begin
            n_done = 1'b1;
            n_res = fres;
            n_pl = '0;
            n_dl = '0;
            n_ovf = 1'b0;
            n_state = sme_pkg::S_IDLE;
        end
    end

    // Outputs and memory read addresses.
    always_comb begin
        o_busy = r_state != sme_pkg::S_IDLE;
        pat_raddr = '0;
        sub_raddr = '0;
        unique case (r_state)
            sme_pkg::S_SAME_A: begin
                pat_raddr = addr_a[PA-1:0];
                sub_raddr = addr_a[SA-1:0];
            end
            sme_pkg::S_SAME_B: begin
                sub_raddr = addr_b[SA-1:0];
            end
            sme_pkg::S_SPAN_A: begin
                sub_raddr = addr_sp[SA-1:0];
            end
            sme_pkg::S_CMP_RD: begin
                pat_raddr = r_ct[PA-1:0];
                sub_raddr = r_ct[SA-1:0];
            end
            default: begin
            end
        endcase
    end

    assign o_done = r_done;
    assign o_res  = r_res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= sme_pkg::S_IDLE;
            r_pl    <= '0;
            r_dl    <= '0;
            r_ovf   <= 1'b0;
            r_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_pl    <= n_pl;
            r_dl    <= n_dl;
            r_ovf   <= n_ovf;
            r_done  <= n_done;
        end
    end

    always_ff @(posedge i_clk) begin
        r_ret <= n_ret;
        r_mode <= n_mode;       r_fold <= n_fold;     r_plain <= n_plain;
        r_ca <= n_ca;           r_cb <= n_cb;         r_cn <= n_cn;   r_ct <= n_ct;
        r_csrc <= n_csrc;       r_same <= n_same;     r_abyte <= n_abyte;
        r_spp <= n_spp;         r_spt <= n_spt;       r_splen <= n_splen;
        r_speq <= n_speq;       r_spend <= n_spend;   r_spch <= n_spch;
        r_p <= n_p;             r_ssrc <= n_ssrc;     r_sp <= n_sp;   r_sl <= n_sl;
        r_red <= n_red;         r_pos <= n_pos;       r_idx <= n_idx; r_j <= n_j;
        r_prevend <= n_prevend; r_dend <= n_dend;     r_dch <= n_dch;
        r_res <= n_res;
    end

`ifndef SYNTH
    // A result is only shown once the sequencer has returned to idle.
    a_done_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> !o_busy)
        else $error("result strobe while busy");

    // Any error forces a zero value.
    a_err_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && o_res.error_code != sme_pkg::ERR_OK) |-> o_res.match_value == '0)
        else $error("nonzero value with error");

    // An accepted run request makes the block busy or yields a result.
    a_run_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_start && !o_busy && i_req.kind == sme_pkg::KIND_RUN) |=> (o_busy || o_done))
        else $error("run request not started");

    // Loads never produce a result.
    a_load_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_start && !o_busy && i_req.kind != sme_pkg::KIND_RUN) |=> !o_done)
        else $error("result after load request");
`endif

endmodule
